// ===== design/fa_pkg.sv =====
package fa_pkg;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_ACCESS = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_NOTUSED = 2'd2;

    localparam logic [1:0] USE_PAGE  = 2'd0;
    localparam logic [1:0] USE_TABLE = 2'd1;
    localparam logic [1:0] USE_DIR   = 2'd2;
    localparam logic [1:0] USE_SPARE = 2'd3;

    localparam int IDX_W = 10;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] frame_index;
        logic [1:0]       frame_kind;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_frame;
        logic             was_evicted;
        logic [1:0]       status;
    } rsp_t;

endpackage

// ===== design/fa_if.sv =====
interface fa_req_if;
    logic          valid;
    logic          ready;
    fa_pkg::req_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fa_rsp_if;
    logic          valid;
    logic          ready;
    fa_pkg::rsp_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/frame_allocator_fifo_aging_evict_top.sv =====
// Channel | Dir | Payload                                | Beat
// req     | in  | kind, frame_index, frame_kind          | valid & ready
// rsp     | out | granted_frame, was_evicted, status     | valid & ready
// cfg     | in  | replace_policy (cfg_wdata[0])          | cfg_we
//
// From the accepting edge to the result register: request kind 3 passes S_RD and S_OUT,
// access adds S_OP, free adds S_OP and S_UNL, allocate from the free queue S_ALLOC and S_APP.
// Allocate with an empty free queue walks the occupied list entry by entry
// (link read, state read, evaluate and write back), then unlinks and appends.
// After reset a clearing pass over all FRAME_COUNT frames initializes frame state;
// no request is taken until it ends. The result sits in an output register;
// a stalled rsp holds the block before it takes the next request.
module frame_allocator_fifo_aging_evict_top #(
    parameter int FRAME_COUNT = 1024,
    parameter int AGE_BITS    = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    fa_req_if.sink    req,
    fa_rsp_if.source  rsp
);
    localparam int AW = $clog2(FRAME_COUNT);
    localparam int CW = AW + 1;
    // frame state word: in_use, accessed, usage kind, age
    localparam int SW = 4 + AGE_BITS;
    localparam logic [CW-1:0] FULL = CW'(FRAME_COUNT);
    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_ALLOC = 4'd3;
    localparam logic [3:0] S_OP    = 4'd4;
    localparam logic [3:0] S_SLINK = 4'd5;
    localparam logic [3:0] S_SST   = 4'd6;
    localparam logic [3:0] S_SEVAL = 4'd7;
    localparam logic [3:0] S_UNL   = 4'd8;
    localparam logic [3:0] S_UNL2  = 4'd9;
    localparam logic [3:0] S_APP   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] st_reg, st_next;
    logic policy_reg;
    logic [AW-1:0] init_reg;
    logic [CW-1:0] free_cnt_reg, occ_cnt_reg, scan_cnt_reg;
    logic [AW-1:0] free_head_reg, free_tail_reg, occ_head_reg, occ_tail_reg;
    logic [AW-1:0] cur_reg, best_reg, vic_p_reg, vic_n_reg, tgt_reg;
    logic [AGE_BITS-1:0] best_age_reg;
    logic found_reg, evict_reg, free_op_reg;
    fa_pkg::req_t r_reg;
    fa_pkg::rsp_t out_reg;
    logic out_v_reg;

    // memories
    logic fn_we; logic [AW-1:0] fn_wa, fn_wd, fn_ra, fn_rd;
    logic on_we; logic [AW-1:0] on_wa, on_wd, on_ra, on_rd;
    logic op_we; logic [AW-1:0] op_wa, op_wd, op_ra, op_rd;
    logic sm_we; logic [AW-1:0] sm_wa, sm_ra; logic [SW-1:0] sm_wd, sm_rd;

    // free links: the clearing pass after reset seeds each slot with index+1.
    fa_ram #(.WIDTH(AW), .DEPTH(FRAME_COUNT)) u_fnext (.clk, .we(fn_we),
        .waddr(fn_wa), .wdata(fn_wd), .raddr(fn_ra), .rdata(fn_rd));
    fa_ram #(.WIDTH(AW), .DEPTH(FRAME_COUNT)) u_onext (.clk, .we(on_we),
        .waddr(on_wa), .wdata(on_wd), .raddr(on_ra), .rdata(on_rd));
    fa_ram #(.WIDTH(AW), .DEPTH(FRAME_COUNT)) u_oprev (.clk, .we(op_we),
        .waddr(op_wa), .wdata(op_wd), .raddr(op_ra), .rdata(op_rd));
    fa_ram #(.WIDTH(SW), .DEPTH(FRAME_COUNT)) u_state (.clk, .we(sm_we),
        .waddr(sm_wa), .wdata(sm_wd), .raddr(sm_ra), .rdata(sm_rd));

    logic s_use, s_acc; logic [1:0] s_kind; logic [AGE_BITS-1:0] s_age;
    assign {s_use, s_acc, s_kind, s_age} = sm_rd;
    logic [AGE_BITS-1:0] aged;
    assign aged = {s_acc, s_age[AGE_BITS-1:1]};

    assign req.ready = (st_reg == S_IDLE) && !out_v_reg;
    assign rsp.valid = out_v_reg;
    assign rsp.data  = out_reg;

    logic in_range;
    assign in_range = (32'(r_reg.frame_index) < 32'(FRAME_COUNT));
    logic [AW-1:0] req_frame;
    assign req_frame = AW'(r_reg.frame_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            policy_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_INIT;
            init_reg      <= '0;
            free_cnt_reg  <= FULL;
            occ_cnt_reg   <= '0;
            free_head_reg <= '0;
            free_tail_reg <= AW'(FRAME_COUNT - 1);
            occ_head_reg  <= '0;
            occ_tail_reg  <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_INIT)
            begin
                init_reg <= init_reg + 1'b1;
            end
            if (rsp.valid && rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (st_reg == S_OUT)
            begin
                out_v_reg <= 1'b1;
            end
            unique case (st_reg)
                S_ALLOC:
                begin
                    free_head_reg <= fn_rd;
                    free_cnt_reg  <= free_cnt_reg - 1'b1;
                end
                S_UNL:
                begin
                    if (tgt_reg == occ_head_reg) occ_head_reg <= vic_n_reg;
                    if (tgt_reg == occ_tail_reg) occ_tail_reg <= vic_p_reg;
                    occ_cnt_reg <= occ_cnt_reg - 1'b1;
                    if (free_op_reg)
                    begin
                        if (free_cnt_reg == '0) free_head_reg <= tgt_reg;
                        free_tail_reg <= tgt_reg;
                        free_cnt_reg  <= free_cnt_reg + 1'b1;
                    end
                end
                S_APP:
                begin
                    if (occ_cnt_reg == '0) occ_head_reg <= tgt_reg;
                    occ_tail_reg <= tgt_reg;
                    occ_cnt_reg  <= occ_cnt_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            r_reg <= req.data;
        end
        unique case (st_reg)
            S_RD:
            begin
                found_reg    <= 1'b0;
                evict_reg    <= 1'b0;
                free_op_reg  <= (r_reg.kind == fa_pkg::REQ_FREE);
                cur_reg      <= occ_head_reg;
                scan_cnt_reg <= occ_cnt_reg;
                tgt_reg      <= (r_reg.kind == fa_pkg::REQ_ALLOC) ? free_head_reg
                                : req_frame;
                out_reg <= '{granted_frame: r_reg.frame_index,
                             was_evicted: 1'b0, status: fa_pkg::ST_OK};
            end
            S_ALLOC:
            begin
                out_reg.granted_frame <= fa_pkg::IDX_W'(tgt_reg);
            end
            S_OP:
            begin
                vic_p_reg <= op_rd;
                vic_n_reg <= on_rd;
                if (!in_range || !s_use)
                begin
                    out_reg.status <= fa_pkg::ST_NOTUSED;
                end
            end
            S_SLINK:
            begin
                // hold next link while state read is in flight
                vic_n_reg <= on_rd;
            end
            S_SEVAL:
            begin
                if (s_kind == fa_pkg::USE_PAGE)
                begin
                    if (!found_reg || (policy_reg && aged < best_age_reg))
                    begin
                        best_reg     <= cur_reg;
                        best_age_reg <= aged;
                        found_reg    <= 1'b1;
                    end
                end
                cur_reg      <= vic_n_reg;
                scan_cnt_reg <= scan_cnt_reg - 1'b1;
            end
            S_SST:
            begin
                if (scan_cnt_reg == '0)
                begin
                    if (found_reg)
                    begin
                        tgt_reg   <= best_reg;
                        evict_reg <= 1'b1;
                        out_reg.granted_frame <= fa_pkg::IDX_W'(best_reg);
                        out_reg.was_evicted   <= 1'b1;
                    end
                    else
                    begin
                        out_reg.granted_frame <= '0;
                        out_reg.status        <= fa_pkg::ST_NONE;
                    end
                end
            end
            default: ;
        endcase
        if (st_reg == S_UNL2)
        begin
            vic_p_reg <= op_rd;
            vic_n_reg <= on_rd;
        end
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_INIT:  if (init_reg == AW'(FRAME_COUNT - 1)) st_next = S_IDLE;
            S_IDLE:  if (req.valid && req.ready) st_next = S_RD;
            S_RD:
            begin
                if (r_reg.kind == fa_pkg::REQ_ALLOC)
                    st_next = (free_cnt_reg != '0) ? S_ALLOC : S_SST;
                else if (r_reg.kind == fa_pkg::REQ_FREE
                         || r_reg.kind == fa_pkg::REQ_ACCESS)
                    st_next = S_OP;
                else
                    st_next = S_OUT;
            end
            S_ALLOC: st_next = S_APP;
            S_OP:
            begin
                if (!in_range || !s_use || !free_op_reg) st_next = S_OUT;
                else st_next = S_UNL;
            end
            S_SST:
            begin
                if (scan_cnt_reg != '0) st_next = S_SLINK;
                else if (found_reg) st_next = S_UNL2;
                else st_next = S_OUT;
            end
            S_SLINK: st_next = S_SEVAL;
            S_SEVAL: st_next = S_SST;
            S_UNL2:  st_next = S_UNL;
            S_UNL:   st_next = free_op_reg ? S_OUT : S_APP;
            S_APP:   st_next = S_OUT;
            S_OUT:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    // memory ports
    always_comb
    begin
        fn_we = 1'b0; fn_wa = free_tail_reg; fn_wd = tgt_reg; fn_ra = free_head_reg;
        on_we = 1'b0; on_wa = tgt_reg; on_wd = tgt_reg; on_ra = tgt_reg;
        op_we = 1'b0; op_wa = tgt_reg; op_wd = tgt_reg; op_ra = tgt_reg;
        sm_we = 1'b0; sm_wa = tgt_reg; sm_wd = '0; sm_ra = tgt_reg;
        unique case (st_reg)
            S_INIT:
            begin
                // seed the free chain and clear frame state
                fn_we = 1'b1; fn_wa = init_reg; fn_wd = init_reg + 1'b1;
                sm_we = 1'b1; sm_wa = init_reg;
            end
            S_RD:
            begin
                sm_ra = req_frame;
                on_ra = req_frame;
                op_ra = req_frame;
            end
            S_OP:
            begin
                if (in_range && s_use && !free_op_reg)
                begin
                    sm_we = 1'b1;
                    sm_wd = {1'b1, 1'b1, s_kind, s_age};
                end
            end
            S_SST:
            begin
                on_ra = cur_reg;
                if (scan_cnt_reg == '0)
                begin
                    on_ra = best_reg; op_ra = best_reg;
                end
            end
            S_SLINK: sm_ra = cur_reg;
            S_SEVAL:
            begin
                if (policy_reg && s_kind == fa_pkg::USE_PAGE)
                begin
                    sm_we = 1'b1; sm_wa = cur_reg;
                    sm_wd = {s_use, 1'b0, s_kind, aged};
                end
            end
            S_UNL:
            begin
                if (tgt_reg != occ_head_reg)
                begin
                    on_we = 1'b1; on_wa = vic_p_reg; on_wd = vic_n_reg;
                end
                if (tgt_reg != occ_tail_reg)
                begin
                    op_we = 1'b1; op_wa = vic_n_reg; op_wd = vic_p_reg;
                end
                if (free_op_reg)
                begin
                    fn_we = (free_cnt_reg != '0);
                    sm_we = 1'b1; sm_wd = '0;
                end
            end
            S_APP:
            begin
                if (occ_cnt_reg != '0)
                begin
                    on_we = 1'b1; on_wa = occ_tail_reg;
                    op_we = 1'b1; op_wd = occ_tail_reg;
                end
                sm_we = 1'b1;
                sm_wd = {1'b1, 1'b0, r_reg.frame_kind,
                         (evict_reg && policy_reg) ? AGE_TOP : '0};
            end
            default: ;
        endcase
    end

    // Between requests the free queue and occupied list together hold the pool.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_IDLE) |-> (free_cnt_reg + occ_cnt_reg == FULL))
        else $error("frame count lost");
    // A new result never appears while the previous one is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_OUT) |-> !out_v_reg)
        else $error("result overrun");
    // Eviction only happens when the free queue is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_UNL2) |-> (free_cnt_reg == '0))
        else $error("eviction with free frames");
endmodule

// ===== design/fa_ram.sv =====
module fa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sim/frame_allocator_fifo_aging_evict_top_tb.sv =====
module frame_allocator_fifo_aging_evict_top_tb;

    localparam int FRAMES    = 1024;
    localparam int CYC_LIMIT = 20000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    fa_req_if req_ch ();
    fa_rsp_if rsp_ch ();

    frame_allocator_fifo_aging_evict_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // Mirror of the frame pool, kept in step with every accepted request beat.
    logic [9:0]  pool_free_next [FRAMES];
    logic [9:0]  pool_occ_next  [FRAMES];
    logic [9:0]  pool_occ_prev  [FRAMES];
    logic        pool_in_use    [FRAMES];
    logic [1:0]  pool_use       [FRAMES];
    logic [7:0]  pool_age       [FRAMES];
    logic        pool_marked    [FRAMES];
    int          free_head;
    int          free_tail;
    int          free_cnt;
    int          occ_head;
    int          occ_tail;
    int          occ_cnt;
    logic        policy_aging;

    fa_pkg::rsp_t grant_queue [$];
    int          cycle_count;
    int          fail_count;
    int          long_stall;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYC_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic pool_reset();
        for (int i = 0; i < FRAMES; i++)
        begin
            pool_free_next[i] = 10'((i + 1) % FRAMES);
            pool_occ_next[i]  = '0;
            pool_occ_prev[i]  = '0;
            pool_in_use[i]    = 1'b0;
            pool_use[i]       = '0;
            pool_age[i]       = '0;
            pool_marked[i]    = 1'b0;
        end
        free_head    = 0;
        free_tail    = FRAMES - 1;
        free_cnt     = FRAMES;
        occ_head     = 0;
        occ_tail     = 0;
        occ_cnt      = 0;
        policy_aging = 1'b0;
    endtask

    task automatic occ_link_tail(input int f);
        if (occ_cnt == 0)
            occ_head = f;
        else
        begin
            pool_occ_next[occ_tail] = 10'(f);
            pool_occ_prev[f]        = 10'(occ_tail);
        end
        occ_tail = f;
        occ_cnt++;
    endtask

    task automatic occ_cut(input int f);
        int p;
        int n;
        p = pool_occ_prev[f];
        n = pool_occ_next[f];
        if (f == occ_head)
            occ_head = n;
        else
            pool_occ_next[p] = 10'(n);
        if (f == occ_tail)
            occ_tail = p;
        else
            pool_occ_prev[n] = 10'(p);
        occ_cnt--;
    endtask

    // Walk the occupied list; age page frames under aging and pick the victim.
    task automatic choose_victim(output bit found, output int victim);
        int cur;
        cur    = occ_head;
        found  = 1'b0;
        victim = 0;
        for (int i = 0; i < occ_cnt; i++)
        begin
            if (pool_use[cur] == fa_pkg::USE_PAGE)
            begin
                if (!policy_aging)
                begin
                    found  = 1'b1;
                    victim = cur;
                    return;
                end
                pool_age[cur] = pool_age[cur] >> 1;
                if (pool_marked[cur])
                begin
                    pool_age[cur][7] = 1'b1;
                    pool_marked[cur] = 1'b0;
                end
                if (!found || pool_age[cur] < pool_age[victim])
                begin
                    victim = cur;
                    found  = 1'b1;
                end
            end
            cur = pool_occ_next[cur];
        end
    endtask

    task automatic predict_grant(input fa_pkg::req_t r, output fa_pkg::rsp_t g);
        int  f;
        bit  found;
        g.granted_frame = r.frame_index;
        g.was_evicted   = 1'b0;
        g.status        = fa_pkg::ST_OK;
        if (r.kind == fa_pkg::REQ_ALLOC)
        begin
            if (free_cnt != 0)
            begin
                f              = free_head;
                free_head      = pool_free_next[f];
                free_cnt--;
                pool_in_use[f] = 1'b1;
                pool_use[f]    = r.frame_kind;
                pool_age[f]    = '0;
                pool_marked[f] = 1'b0;
                occ_link_tail(f);
                g.granted_frame = 10'(f);
            end
            else
            begin
                choose_victim(found, f);
                if (found)
                begin
                    occ_cut(f);
                    occ_link_tail(f);
                    pool_use[f]     = r.frame_kind;
                    pool_marked[f]  = 1'b0;
                    pool_age[f]     = policy_aging ? 8'h80 : 8'h00;
                    g.granted_frame = 10'(f);
                    g.was_evicted   = 1'b1;
                end
                else
                begin
                    g.granted_frame = '0;
                    g.status        = fa_pkg::ST_NONE;
                end
            end
        end
        else if (r.kind == fa_pkg::REQ_FREE || r.kind == fa_pkg::REQ_ACCESS)
        begin
            f = r.frame_index;
            if (!pool_in_use[f])
                g.status = fa_pkg::ST_NOTUSED;
            else if (r.kind == fa_pkg::REQ_FREE)
            begin
                occ_cut(f);
                if (free_cnt == 0)
                    free_head = f;
                else
                    pool_free_next[free_tail] = 10'(f);
                free_tail = f;
                free_cnt++;
                pool_in_use[f] = 1'b0;
                pool_age[f]    = '0;
                pool_marked[f] = 1'b0;
            end
            else
                pool_marked[f] = 1'b1;
        end
    endtask

    // Predict on every accepted request beat, so held-off results still queue up.
    always @(posedge clk)
    begin
        fa_pkg::rsp_t g;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            predict_grant(req_ch.data, g);
            grant_queue.push_back(g);
        end
    end

    // Check each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        fa_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (grant_queue.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, rsp_ch.data);
                fail_count++;
            end
            else
            begin
                want = grant_queue.pop_front();
                if (rsp_ch.data.granted_frame !== want.granted_frame)
                begin
                    $display("%0t: granted_frame expected %0d actual %0d", $time,
                             want.granted_frame, rsp_ch.data.granted_frame);
                    fail_count++;
                end
                if (rsp_ch.data.was_evicted !== want.was_evicted)
                begin
                    $display("%0t: was_evicted expected %0d actual %0d", $time,
                             want.was_evicted, rsp_ch.data.was_evicted);
                    fail_count++;
                end
                if (rsp_ch.data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.data.status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls on its own pattern; a long hold-off overrides it.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (long_stall > 0)
        begin
            rsp_ch.ready <= 1'b0;
            long_stall   <= long_stall - 1;
        end
        else if (cycle_count[9:8] == 2'b11)
            rsp_ch.ready <= 1'b1;
        else
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // Hold valid until the beat is taken, then drop it or move to the next item.
    int burst_left;
    task automatic send_req(input logic [1:0] k, input logic [9:0] idx,
                            input logic [1:0] fk);
        fa_pkg::req_t r;
        int   gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        r.kind        = k;
        r.frame_index = idx;
        r.frame_kind  = fk;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic idle_sender();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Pause until every prediction has been matched, then let the block settle.
    task automatic drain();
        idle_sender();
        while (grant_queue.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_policy(input logic aging);
        drain();
        cfg_we       <= 1'b1;
        cfg_wdata    <= aging;
        @(posedge clk);
        cfg_we       <= 1'b0;
        policy_aging = aging;
    endtask

    // Pick an in-use frame most of the time, any frame otherwise.
    function automatic logic [9:0] pick_frame();
        int f;
        for (int t = 0; t < 8; t++)
        begin
            f = $urandom_range(0, FRAMES - 1);
            if (pool_in_use[f])
                return 10'(f);
        end
        return 10'($urandom);
    endfunction

    function automatic logic [1:0] pick_use();
        int r;
        r = $urandom_range(0, 9);
        return (r < 7) ? fa_pkg::USE_PAGE : 2'($urandom_range(1, 3));
    endfunction

    task automatic test_directed_edges();
        send_req(fa_pkg::REQ_FREE, 10'd0, fa_pkg::USE_PAGE);
        send_req(fa_pkg::REQ_ACCESS, 10'd1023, fa_pkg::USE_SPARE);
        send_req(fa_pkg::REQ_NOP, 10'h3ff, fa_pkg::USE_SPARE);
        send_req(fa_pkg::REQ_ALLOC, 10'h3ff, fa_pkg::USE_PAGE);
        send_req(fa_pkg::REQ_ALLOC, 10'h155, fa_pkg::USE_TABLE);
        send_req(fa_pkg::REQ_ALLOC, 10'h2aa, fa_pkg::USE_DIR);
        send_req(fa_pkg::REQ_ALLOC, 10'h000, fa_pkg::USE_SPARE);
        send_req(fa_pkg::REQ_ACCESS, 10'd0, fa_pkg::USE_PAGE);
        send_req(fa_pkg::REQ_FREE, 10'd1, fa_pkg::USE_PAGE);
        send_req(fa_pkg::REQ_FREE, 10'd1, fa_pkg::USE_PAGE);
        send_req(fa_pkg::REQ_ACCESS, 10'd3, fa_pkg::USE_PAGE);
        send_req(fa_pkg::REQ_FREE, 10'd3, fa_pkg::USE_PAGE);
        send_req(fa_pkg::REQ_ALLOC, 10'd0, fa_pkg::USE_PAGE);
    endtask

    // Fill the pool with mostly non-page frames, then evict once the free queue is dry.
    task automatic test_fill_and_evict(input int allocs);
        for (int i = 0; i < allocs; i++)
        begin
            if (i < allocs - 12)
                send_req(fa_pkg::REQ_ALLOC, 10'($urandom), 2'($urandom_range(1, 3)));
            else
                send_req(fa_pkg::REQ_ALLOC, 10'($urandom), fa_pkg::USE_PAGE);
        end
    endtask

    task automatic test_random_mix(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_req(fa_pkg::REQ_ALLOC, 10'($urandom), pick_use());
            else if (r < 65)
                send_req(fa_pkg::REQ_FREE, pick_frame(), 2'($urandom));
            else if (r < 97)
                send_req(fa_pkg::REQ_ACCESS, pick_frame(), 2'($urandom));
            else
                send_req(fa_pkg::REQ_NOP, 10'($urandom), 2'($urandom));
        end
    endtask

    task automatic test_no_page_frames();
        // Free every page frame so an allocate finds nothing to evict.
        for (int i = 0; i < FRAMES; i++)
            if (pool_in_use[i] && pool_use[i] == fa_pkg::USE_PAGE)
                send_req(fa_pkg::REQ_FREE, 10'(i), fa_pkg::USE_PAGE);
        while (free_cnt > 0)
            send_req(fa_pkg::REQ_ALLOC, 10'($urandom), 2'($urandom_range(1, 3)));
        send_req(fa_pkg::REQ_ALLOC, 10'h3ff, fa_pkg::USE_PAGE);
        send_req(fa_pkg::REQ_ALLOC, 10'h000, fa_pkg::USE_PAGE);
    endtask

    task automatic test_backpressure();
        drain();
        long_stall = 300;
        for (int i = 0; i < 20; i++)
            send_req(fa_pkg::REQ_ACCESS, pick_frame(), fa_pkg::USE_PAGE);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        cycle_count  = 0;
        fail_count   = 0;
        long_stall   = 0;
        burst_left   = 0;
        pool_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_policy(1'b0);
        test_directed_edges();
        test_backpressure();
        test_fill_and_evict(1024);
        test_random_mix(100);
        set_policy(1'b1);
        test_random_mix(100);
        set_policy(1'b0);
        test_random_mix(60);
        set_policy(1'b1);
        test_no_page_frames();
        drain();
        // Let any trailing eviction scan run out.
        repeat (3 * FRAMES + 50) @(posedge clk);

        if (fail_count == 0 && grant_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
